### rtl/slru_pkg.sv
package slru_pkg;

  localparam int unsigned DEF_ENTRIES = 64;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned VPN_W       = 32;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned PIN_LIM_W   = 5;
  localparam int unsigned PIN_CNT_W   = 6;

  localparam logic [PIN_LIM_W-1:0] MAX_PINNED_RST = PIN_LIM_W'(8);

  localparam logic [OP_W-1:0] OP_GET    = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
  localparam logic [OP_W-1:0] OP_EVICT  = 3'd3;
  localparam logic [OP_W-1:0] OP_PIN    = 3'd4;
  localparam logic [OP_W-1:0] OP_UNPIN  = 3'd5;

  typedef struct packed {
    logic             hit;
    logic             hprot;
    logic             hpin;
    logic [VPN_W-1:0] hval;
    logic             vfound;
    logic [KEY_W-1:0] vkey;
    logic [VPN_W-1:0] vval;
    logic             vdirty;
    logic             free;
  } scan_acc_t;

  typedef struct packed {
    logic             en;
    logic             get_prot;
    logic             get_prob;
    logic             demote;
    logic             add;
    logic             update;
    logic             evict;
    logic             pin;
    logic             unpin;
    logic [KEY_W-1:0] key;
    logic [VPN_W-1:0] vpn;
  } cell_cmd_t;

endpackage

### rtl/slru_ifs.sv
interface slru_req_if import slru_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [KEY_W-1:0] key_in;
  logic [VPN_W-1:0] vpn_in;
  modport source (output valid, opcode, key_in, vpn_in, input ready);
  modport sink (input valid, opcode, key_in, vpn_in, output ready);
endinterface

interface slru_rsp_if import slru_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             fail;
  logic [VPN_W-1:0] vpn_out;
  logic [KEY_W-1:0] key_out;
  logic             dirty_out;
  logic             full_res;
  modport source (output valid, fail, vpn_out, key_out, dirty_out, full_res, input ready);
  modport sink (input valid, fail, vpn_out, key_out, dirty_out, full_res, output ready);
endinterface

interface slru_cfg_if import slru_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PIN_LIM_W-1:0] max_pinned;
  modport source (output valid, max_pinned, input ready);
  modport sink (input valid, max_pinned, output ready);
endinterface

### rtl/slru_cell.sv
module slru_cell import slru_pkg::*; #(
  parameter int unsigned RANK_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              tok_in,
  input  scan_acc_t         acc_in,
  input  logic [RANK_W-1:0] hrank_in,
  input  logic [RANK_W-1:0] vrank_in,
  output logic              tok_out,
  output scan_acc_t         acc_out,
  output logic [RANK_W-1:0] hrank_out,
  output logic [RANK_W-1:0] vrank_out,
  input  cell_cmd_t         cmd,
  input  logic [RANK_W-1:0] cmd_hrank,
  input  logic [RANK_W-1:0] cmd_vrank,
  input  logic [RANK_W-1:0] cmd_pcm1
);

  logic [KEY_W-1:0]  key;
  logic [VPN_W-1:0]  value;
  logic              valid;
  logic              dirty;
  logic              prot;
  logic              pinned;
  logic [RANK_W-1:0] rank;
  logic              claim;

  logic              hit;
  logic              elig;
  logic              take_v;
  logic              gt_h;
  logic              victim;

  scan_acc_t         acc_next;
  logic [RANK_W-1:0] hrank_next;
  logic [RANK_W-1:0] vrank_next;

  assign hit    = valid && (key == cmd.key);
  assign elig   = valid && !prot && !pinned;
  assign take_v = elig && (!acc_in.vfound || rank > vrank_in);
  assign gt_h   = rank > cmd_hrank;
  assign victim = elig && (rank == cmd_vrank);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
      claim   <= 1'b0;
    end else begin
      tok_out <= tok_in;
      if (tok_in) begin
        claim <= !valid && !acc_in.free;
      end
    end
  end

  always_comb begin
    acc_next      = acc_in;
    hrank_next    = hrank_in;
    vrank_next    = vrank_in;
    acc_next.free = acc_in.free || !valid;
    if (hit && !acc_in.hit) begin
      acc_next.hit   = 1'b1;
      acc_next.hprot = prot;
      acc_next.hpin  = pinned;
      acc_next.hval  = value;
      hrank_next     = rank;
    end
    if (take_v) begin
      acc_next.vfound = 1'b1;
      acc_next.vkey   = key;
      acc_next.vval   = value;
      acc_next.vdirty = dirty;
      vrank_next      = rank;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in) begin
      acc_out   <= acc_next;
      hrank_out <= hrank_next;
      vrank_out <= vrank_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en && cmd.add && claim) begin
      key <= cmd.key;
    end
    if (cmd.en && ((cmd.add && claim) ||
                   (cmd.update && hit && value != cmd.vpn))) begin
      value <= cmd.vpn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      dirty  <= 1'b0;
      prot   <= 1'b0;
      pinned <= 1'b0;
      rank   <= '0;
    end else if (cmd.en) begin
      if (cmd.get_prot) begin
        if (hit) begin
          rank <= '0;
        end else if (valid && prot && rank < cmd_hrank) begin
          rank <= rank + RANK_W'(1);
        end
      end
      if (cmd.get_prob) begin
        if (hit) begin
          prot <= 1'b1;
          rank <= '0;
        end else if (valid && prot) begin
          if (cmd.demote && rank == cmd_pcm1) begin
            prot <= 1'b0;
            rank <= '0;
          end else begin
            rank <= rank + RANK_W'(1);
          end
        end else if (valid) begin
          rank <= rank + RANK_W'(cmd.demote) - RANK_W'(gt_h);
        end
      end
      if (cmd.add) begin
        if (claim) begin
          valid  <= 1'b1;
          dirty  <= 1'b0;
          pinned <= 1'b0;
          prot   <= 1'b0;
          rank   <= '0;
        end else if (valid && !prot) begin
          rank <= rank + RANK_W'(1);
        end
      end
      if (cmd.update && hit && value != cmd.vpn) begin
        dirty <= 1'b1;
      end
      if (cmd.evict) begin
        if (victim) begin
          valid <= 1'b0;
        end else if (valid && !prot && rank > cmd_vrank) begin
          rank <= rank - RANK_W'(1);
        end
      end
      if (cmd.pin && hit) begin
        pinned <= 1'b1;
      end
      if (cmd.unpin && hit) begin
        pinned <= 1'b0;
      end
    end
  end

endmodule

### rtl/slru_mapping_cache_unit.sv
// Segmented-LRU cache of logical-to-physical page mappings.
// req carries one operation per transaction (opcode, key_in, vpn_in); rsp
// returns exactly one result transaction per request (fail, vpn_out,
// key_out, dirty_out, full_res); cfg writes max_pinned and is always ready.
// Each entry lives in one cell of a chain of ENTRIES cells. The cycle after
// a request is accepted, a scan token enters the chain and walks it one cell
// per cycle, gathering the key match, the eviction victim and the first free
// slot. When the token leaves the last cell, a single broadcast cycle updates
// all cells and loads the result register. One request is in flight at a
// time: the next is taken only after the previous one commits, so
// throughput is set by the length of the chain.
// The next request is taken while a result waits in the output register;
// if the receiver stalls, the following commit waits until rsp is free.
// Reset empties the cache, clears all counts and sets max_pinned to 8.
module slru_mapping_cache_unit import slru_pkg::*; #(
  parameter int unsigned ENTRIES = DEF_ENTRIES
) (
  input logic           clk,
  input logic           rst,
  slru_req_if.sink      req,
  slru_rsp_if.source    rsp,
  slru_cfg_if.sink      cfg
);

  localparam int unsigned HALF   = ENTRIES / 2;
  localparam int unsigned RANK_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W  = $clog2(HALF) + 1;
  localparam logic [CNT_W-1:0] HALF_CNT = CNT_W'(HALF);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [PIN_LIM_W-1:0] max_pinned;
  logic [CNT_W-1:0]     prot_cnt;
  logic [CNT_W-1:0]     prob_cnt;
  logic [PIN_CNT_W-1:0] pin_cnt;
  logic [CNT_W-1:0]     prot_cnt_next;
  logic [CNT_W-1:0]     prob_cnt_next;
  logic [PIN_CNT_W-1:0] pin_cnt_next;
  logic [OP_W-1:0]      op;
  logic [KEY_W-1:0]     op_key;
  logic [VPN_W-1:0]     op_vpn;
  logic                 launch;

  logic                 tok [ENTRIES+1];
  scan_acc_t            acc [ENTRIES+1];
  logic [RANK_W-1:0]    hrank [ENTRIES+1];
  logic [RANK_W-1:0]    vrank [ENTRIES+1];

  cell_cmd_t            cmd;
  scan_acc_t            res;
  logic                 commit;
  logic                 fail;
  logic [VPN_W-1:0]     vo;
  logic [KEY_W-1:0]     ko;
  logic                 dty;
  logic                 accept;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign commit    = (state == ST_COMMIT) && (!rsp.valid || rsp.ready);
  assign res       = acc[ENTRIES];

  assign tok[0]   = launch;
  assign acc[0]   = '0;
  assign hrank[0] = '0;
  assign vrank[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    slru_cell #(
      .RANK_W (RANK_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .tok_in    (tok[i]),
      .acc_in    (acc[i]),
      .hrank_in  (hrank[i]),
      .vrank_in  (vrank[i]),
      .tok_out   (tok[i+1]),
      .acc_out   (acc[i+1]),
      .hrank_out (hrank[i+1]),
      .vrank_out (vrank[i+1]),
      .cmd       (cmd),
      .cmd_hrank (hrank[ENTRIES]),
      .cmd_vrank (vrank[ENTRIES]),
      .cmd_pcm1  (RANK_W'(prot_cnt - CNT_W'(1)))
    );
  end

  always_comb begin
    cmd           = '0;
    cmd.en        = commit;
    cmd.key       = op_key;
    cmd.vpn       = op_vpn;
    fail          = 1'b1;
    vo            = '0;
    ko            = '0;
    dty           = 1'b0;
    prot_cnt_next = prot_cnt;
    prob_cnt_next = prob_cnt;
    pin_cnt_next  = pin_cnt;
    case (op)
      OP_GET: begin
        if (res.hit) begin
          fail         = 1'b0;
          vo           = res.hval;
          cmd.get_prot = res.hprot;
          cmd.get_prob = !res.hprot;
          cmd.demote   = !res.hprot && (prot_cnt >= HALF_CNT);
          if (!res.hprot) begin
            prot_cnt_next = prot_cnt + CNT_W'(1) - CNT_W'(cmd.demote);
            prob_cnt_next = prob_cnt - CNT_W'(1) + CNT_W'(cmd.demote);
          end
        end
      end
      OP_ADD: begin
        if (!res.hit && prob_cnt < HALF_CNT && res.free) begin
          fail          = 1'b0;
          cmd.add       = 1'b1;
          prob_cnt_next = prob_cnt + CNT_W'(1);
        end
      end
      OP_UPDATE: begin
        if (res.hit) begin
          fail       = 1'b0;
          cmd.update = 1'b1;
        end
      end
      OP_EVICT: begin
        if (prob_cnt == HALF_CNT && res.vfound) begin
          fail          = 1'b0;
          cmd.evict     = 1'b1;
          vo            = res.vval;
          ko            = res.vkey;
          dty           = res.vdirty;
          prob_cnt_next = prob_cnt - CNT_W'(1);
        end
      end
      OP_PIN: begin
        if (res.hit && pin_cnt < PIN_CNT_W'(max_pinned)) begin
          fail         = 1'b0;
          cmd.pin      = 1'b1;
          pin_cnt_next = pin_cnt + PIN_CNT_W'(1);
        end
      end
      OP_UNPIN: begin
        if (res.hit) begin
          fail      = 1'b0;
          cmd.unpin = 1'b1;
          if (res.hpin && pin_cnt != '0) begin
            pin_cnt_next = pin_cnt - PIN_CNT_W'(1);
          end
        end
      end
      default: begin
        fail = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok[ENTRIES]) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      launch     <= 1'b0;
      max_pinned <= MAX_PINNED_RST;
      prot_cnt   <= '0;
      prob_cnt   <= '0;
      pin_cnt    <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept;
      if (cfg.valid && cfg.ready) begin
        max_pinned <= cfg.max_pinned;
      end
      if (commit) begin
        prot_cnt  <= prot_cnt_next;
        prob_cnt  <= prob_cnt_next;
        pin_cnt   <= pin_cnt_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= req.opcode;
      op_key <= req.key_in;
      op_vpn <= req.vpn_in;
    end
    if (commit) begin
      rsp.fail      <= fail;
      rsp.vpn_out   <= vo;
      rsp.key_out   <= ko;
      rsp.dirty_out <= dty;
      rsp.full_res  <= (prob_cnt_next == HALF_CNT);
    end
  end

  a_prot_bound: assert property (@(posedge clk) disable iff (rst)
    prot_cnt <= HALF_CNT) else $error("protected count above half capacity");

  a_prob_bound: assert property (@(posedge clk) disable iff (rst)
    prob_cnt <= HALF_CNT) else $error("probationary count above half capacity");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SCAN) else $error("accepted transaction did not start a scan");

  a_token_scan: assert property (@(posedge clk) disable iff (rst)
    tok[ENTRIES] |-> state == ST_SCAN) else $error("scan token left chain outside a scan");

  a_commit_once: assert property (@(posedge clk) disable iff (rst)
    commit |=> !commit) else $error("two commits in a row");

endmodule

### test/slru_checker.sv
module slru_checker import slru_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  slru_req_if        req,
  slru_rsp_if        rsp,
  slru_cfg_if        cfg,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N    = DEF_ENTRIES;
  localparam int HALF = N / 2;

  typedef struct packed {
    logic             fail;
    logic [VPN_W-1:0] vpn;
    logic [KEY_W-1:0] key;
    logic             dirty;
    logic             full;
  } outcome_t;

  outcome_t             outcome_q[$];
  logic [KEY_W-1:0]     slot_key[N];
  logic [VPN_W-1:0]     slot_vpn[N];
  bit                   slot_used[N];
  bit                   slot_dirty[N];
  bit                   slot_prot[N];
  bit                   slot_pin[N];
  int                   slot_rank[N];
  int                   prot_cnt;
  int                   prob_cnt;
  int                   pin_cnt;
  logic [PIN_LIM_W-1:0] pin_limit;

  function automatic int lookup(logic [KEY_W-1:0] k);
    for (int i = 0; i < N; i++) begin
      if (slot_used[i] && slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void close_gap(int s);
    for (int j = 0; j < N; j++) begin
      if (j != s && slot_used[j] && slot_prot[j] == slot_prot[s] && slot_rank[j] > slot_rank[s])
        slot_rank[j]--;
    end
  endfunction

  function automatic void to_front(int s, bit prot);
    for (int j = 0; j < N; j++) begin
      if (j != s && slot_used[j] && slot_prot[j] == prot) slot_rank[j]++;
    end
    slot_prot[s] = prot;
    slot_rank[s] = 0;
  endfunction

  function automatic void promote(int s);
    if (slot_prot[s]) begin
      close_gap(s);
      to_front(s, 1'b1);
      return;
    end
    if (prot_cnt >= HALF && prot_cnt > 0) begin
      for (int j = 0; j < N; j++) begin
        if (slot_used[j] && slot_prot[j] && slot_rank[j] == prot_cnt - 1) begin
          close_gap(j);
          to_front(j, 1'b0);
          prot_cnt--;
          prob_cnt++;
          break;
        end
      end
    end
    close_gap(s);
    prob_cnt--;
    to_front(s, 1'b1);
    prot_cnt++;
  endfunction

  function automatic outcome_t apply_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                        logic [VPN_W-1:0] v);
    outcome_t r;
    int       s;
    int       f;
    int       victim;
    r = '0;
    r.fail = 1'b1;
    s = lookup(k);
    case (op)
      OP_GET: begin
        if (s >= 0) begin
          r.vpn = slot_vpn[s];
          promote(s);
          r.fail = 1'b0;
        end
      end
      OP_ADD: begin
        f = -1;
        for (int j = N - 1; j >= 0; j--) begin
          if (!slot_used[j]) f = j;
        end
        if (prob_cnt < HALF && s < 0 && f >= 0) begin
          slot_key[f] = k;
          slot_vpn[f] = v;
          slot_dirty[f] = 1'b0;
          slot_pin[f] = 1'b0;
          slot_used[f] = 1'b1;
          to_front(f, 1'b0);
          prob_cnt++;
          r.fail = 1'b0;
        end
      end
      OP_UPDATE: begin
        if (s >= 0) begin
          if (slot_vpn[s] != v) begin
            slot_vpn[s] = v;
            slot_dirty[s] = 1'b1;
          end
          r.fail = 1'b0;
        end
      end
      OP_EVICT: begin
        victim = -1;
        if (prob_cnt == HALF) begin
          for (int j = 0; j < N; j++) begin
            if (slot_used[j] && !slot_prot[j] && !slot_pin[j] &&
                (victim < 0 || slot_rank[j] > slot_rank[victim]))
              victim = j;
          end
        end
        if (victim >= 0) begin
          close_gap(victim);
          slot_used[victim] = 1'b0;
          prob_cnt--;
          r.key = slot_key[victim];
          r.vpn = slot_vpn[victim];
          r.dirty = slot_dirty[victim];
          r.fail = 1'b0;
        end
      end
      OP_PIN: begin
        if (s >= 0 && pin_cnt < pin_limit) begin
          slot_pin[s] = 1'b1;
          pin_cnt = (pin_cnt + 1) & 63;
          r.fail = 1'b0;
        end
      end
      OP_UNPIN: begin
        if (s >= 0) begin
          if (slot_pin[s]) begin
            slot_pin[s] = 1'b0;
            if (pin_cnt > 0) pin_cnt--;
          end
          r.fail = 1'b0;
        end
      end
      default: ;
    endcase
    r.full = (prob_cnt == HALF);
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst) begin
      outcome_q.delete();
      for (int i = 0; i < N; i++) begin
        slot_used[i] = 0;
        slot_dirty[i] = 0;
        slot_prot[i] = 0;
        slot_pin[i] = 0;
        slot_rank[i] = 0;
      end
      prot_cnt = 0;
      prob_cnt = 0;
      pin_cnt = 0;
      pin_limit = MAX_PINNED_RST;
      errors = 0;
    end else begin
      if (cfg.valid && cfg.ready) pin_limit = cfg.max_pinned;
      if (req.valid && req.ready)
        outcome_q.push_back(apply_op(req.opcode, req.key_in, req.vpn_in));
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.fail, rsp.vpn_out, rsp.key_out, rsp.dirty_out, rsp.full_res};
        if (outcome_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction: %p", got);
        end else begin
          want = outcome_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, actual %p", want, got);
          end
        end
      end
    end
    pending = outcome_q.size();
  end

endmodule

### test/tb.sv
module tb;
  import slru_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_cycles;
  int   quiet;
  logic [KEY_W-1:0] key_pool[64];

  slru_req_if req_if();
  slru_rsp_if rsp_if();
  slru_cfg_if cfg_if();

  slru_mapping_cache_unit i_dut (
    .clk(clk), .rst(rst), .req(req_if.sink), .rsp(rsp_if.source), .cfg(cfg_if.sink)
  );

  slru_checker i_checker (
    .clk(clk), .rst(rst), .req(req_if), .rsp(rsp_if), .cfg(cfg_if),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    rsp_if.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        rsp_if.ready = 0;
        hold_cycles--;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] k, logic [VPN_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 0;
      @(negedge clk);
    end
    req_if.valid = 1;
    req_if.opcode = op;
    req_if.key_in = k;
    req_if.vpn_in = v;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
    req_if.valid = 0;
  endtask

  task automatic drain();
    req_if.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_limit(logic [PIN_LIM_W-1:0] lim);
    drain();
    cfg_if.valid = 1;
    cfg_if.max_pinned = lim;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 0;
  endtask

  task automatic random_op();
    int               pick;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] k;
    pick = $urandom_range(99);
    if (pick < 30) op = OP_ADD;
    else if (pick < 52) op = OP_GET;
    else if (pick < 62) op = OP_UPDATE;
    else if (pick < 76) op = OP_EVICT;
    else if (pick < 86) op = OP_PIN;
    else if (pick < 96) op = OP_UNPIN;
    else op = OP_W'($urandom_range(7));
    k = ($urandom_range(19) == 0) ? $urandom() : key_pool[$urandom_range(63)];
    send_op(op, k, ($urandom_range(3) == 0) ? 32'(k) : $urandom());
  endtask

  initial begin
    req_if.valid = 0;
    req_if.opcode = OP_GET;
    req_if.key_in = '0;
    req_if.vpn_in = '0;
    cfg_if.valid = 0;
    cfg_if.max_pinned = MAX_PINNED_RST;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 64; i++) key_pool[i] = $urandom();
    rst = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_op(OP_EVICT, '0, '0);
    send_op(OP_ADD, '0, '0);
    send_op(OP_ADD, '1, '1);
    send_op(OP_ADD, '1, 32'h1234);
    send_op(OP_GET, '0, '0);
    send_op(OP_GET, 32'h5a5a_a5a5, '0);
    send_op(OP_UPDATE, '1, '1);
    send_op(OP_UPDATE, '1, 32'h8000_0001);
    send_op(OP_UPDATE, 32'h5a5a_a5a5, '1);
    send_op(OP_PIN, '1, '0);
    send_op(OP_PIN, '1, '0);
    send_op(OP_UNPIN, '1, '0);
    send_op(OP_UNPIN, '1, '0);
    send_op(OP_UNPIN, '0, '0);
    send_op(OP_PIN, 32'h5a5a_a5a5, '0);
    send_op(3'd6, '0, '0);
    send_op(3'd7, '1, '1);
    write_limit('0);
    send_op(OP_PIN, '0, '0);
    write_limit('1);
    send_op(OP_PIN, '0, '0);
    send_op(OP_GET, '1, '0);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      case (phase)
        1: write_limit(5'd1);
        3: write_limit(5'd31);
        5: write_limit(PIN_LIM_W'($urandom_range(31)));
        6: write_limit('0);
        7: write_limit(5'd3);
        default: ;
      endcase
      if (phase == 2) begin
        hold_cycles = 400;
        repeat (6) random_op();
      end
      for (int n = 0; n < 216; n++) random_op();
      if (phase == 4) drain();
    end

    req_if.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/slru_pkg.sv
rtl/slru_ifs.sv
rtl/slru_cell.sv
rtl/slru_mapping_cache_unit.sv
test/slru_checker.sv
test/tb.sv
